/* hdl/fsia_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsia_pkg
// shared types, codes and constants of the floppy sector image access block
// ----------------------------------------------------------------------------
package fsia_pkg;

  // image store geometry
  localparam int IMAGE_ADDR_BITS = 20;
  localparam int IMAGE_DEPTH     = 1 << IMAGE_ADDR_BITS;

  // sector index and end-of-sector widths in the address unit
  localparam int IDX_W     = 24;
  localparam int SHIFT_MAX = 10;
  localparam int END_W     = IDX_W + 1 + SHIFT_MAX;

  // operations
  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_LOAD  = 2'd2;

  // result kinds
  localparam logic [2:0] KIND_BYTE    = 3'd0;
  localparam logic [2:0] KIND_ID      = 3'd1;
  localparam logic [2:0] KIND_INDEX   = 3'd2;
  localparam logic [2:0] KIND_DATA    = 3'd3;
  localparam logic [2:0] KIND_NODATA  = 3'd4;
  localparam logic [2:0] KIND_CRC     = 3'd5;
  localparam logic [2:0] KIND_ERROR   = 3'd6;
  localparam logic [2:0] KIND_REFUSED = 3'd7;

  // special sector numbers
  localparam logic [7:0] SEC_ID    = 8'hfd;
  localparam logic [7:0] SEC_RSVD  = 8'hfe;
  localparam logic [7:0] SEC_INDEX = 8'hff;

  // track mapping codes
  localparam logic [1:0] MAP_HALVE  = 2'd1;
  localparam logic [1:0] MAP_DOUBLE = 2'd2;

  // register indexes
  localparam logic [2:0] REG_SIDE_COUNT   = 3'd0;
  localparam logic [2:0] REG_TRACK_COUNT  = 3'd1;
  localparam logic [2:0] REG_SECTORS      = 3'd2;
  localparam logic [2:0] REG_SIZE_CODE    = 3'd3;
  localparam logic [2:0] REG_INTERLACED   = 3'd4;
  localparam logic [2:0] REG_TRACK_MAP    = 3'd5;
  localparam logic [2:0] REG_TRACK_LENGTH = 3'd6;
  localparam logic [2:0] REG_WRITE_PROT   = 3'd7;

  // disk geometry handed to the address unit
  typedef struct packed {
    logic [1:0] side_count;
    logic [7:0] track_count;
    logic [7:0] sectors_per_track;
    logic [1:0] size_code;
    logic       interlaced;
    logic [1:0] track_mapping;
  } geo_t;

  // answer of the address unit
  typedef struct packed {
    logic                       done;
    logic                       ok;
    logic [IMAGE_ADDR_BITS-1:0] base;
  } addr_res_t;

  // bytes in one sector
  function automatic logic [10:0] sector_bytes(input logic [1:0] code);
    sector_bytes = 11'd128 << code;
  endfunction

endpackage

/* hdl/fsia_sector_addr.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsia_sector_addr
// three-stage sector address unit: track mapping, index products, bound check
// ----------------------------------------------------------------------------
module fsia_sector_addr
  import fsia_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  logic [7:0] track,
  input  logic [7:0] side,
  input  logic [7:0] sector,
  input  geo_t      geo,
  output addr_res_t res
);

  logic [8:0]       t_map;
  logic             reject;
  logic [8:0]       mul_a;
  logic [7:0]       mul_b;
  logic [8:0]       mul_c;
  logic [16:0]      p1_calc;
  logic [IDX_W:0]   idx_calc;
  logic [3:0]       shift;
  logic [END_W-1:0] end_calc;
  logic [END_W-1:0] base_calc;

  // stage registers
  logic             v1;
  logic             v2;
  logic [15:0]      p1;
  logic             bad1;
  logic             bad2;
  logic [7:0]       sec_m1;
  logic [IDX_W-1:0] idx;

  always_comb begin
    t_map  = {1'b0, track};
    reject = (sector == 8'd0);
    if (geo.track_mapping == MAP_HALVE) begin
      t_map = {2'b0, track[7:1]};
      if (track[0]) reject = 1'b1;
    end else if (geo.track_mapping == MAP_DOUBLE) begin
      t_map = {track, 1'b0};
    end
    // interlaced: track * sides + side, else side * tracks + track
    if (geo.interlaced) begin
      mul_a = t_map;
      mul_b = {6'b0, geo.side_count};
      mul_c = {1'b0, side};
    end else begin
      mul_a = {1'b0, side};
      mul_b = geo.track_count;
      mul_c = t_map;
    end
    p1_calc   = 17'(mul_a * mul_b) + 17'(mul_c);
    idx_calc  = (IDX_W+1)'(p1 * geo.sectors_per_track) + (IDX_W+1)'(sec_m1);
    shift     = 4'd7 + {2'b0, geo.size_code};
    end_calc  = (END_W'(idx) + END_W'(1)) << shift;
    base_calc = END_W'(idx) << shift;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      res.done <= 1'b0;
    end else begin
      v1       <= start;
      v2       <= v1;
      res.done <= v2;
    end
    if (start) begin
      p1     <= p1_calc[15:0];
      bad1   <= reject;
      sec_m1 <= sector - 8'd1;
    end
    if (v1) begin
      idx  <= idx_calc[IDX_W-1:0];
      bad2 <= bad1;
    end
    if (v2) begin
      res.ok   <= !bad2 && (end_calc <= (END_W'(1) << IMAGE_ADDR_BITS));
      res.base <= base_calc[IMAGE_ADDR_BITS-1:0];
    end
  end

endmodule

/* hdl/floppy_sector_image_access.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// floppy_sector_image_access
// soft-sectored floppy access over a byte image held in on-chip memory
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid/in_ready) carries one access item: a read, a
//   write, or a load of one image byte at load_address. the image must be
//   loaded before its bytes are read. output channel (out_valid/out_ready)
//   returns exactly one item per input item: kind and value.
//   a negative position opens a field: id mark, index mark, or a data
//   sector located by track, side and sector; then bytes stream until the
//   sector ends and crc is reported.
//   configuration: cfg_write/cfg_index/cfg_data, one register per edge, only
//   while no item is in flight.
// sequencing
//   one item at a time: the next item is accepted only after the last result
//   has been pushed into the output register. a data byte read adds a memory
//   read state for the registered memory data, a sector open waits on the
//   three stages of the sector address unit.
// reset
//   rst is synchronous; it closes the sector, empties the output register
//   and loads the register defaults. image memory is not cleared.
// stall
//   a held result keeps the output register; the block finishes the next item
//   and waits with it until the output register frees.
// ----------------------------------------------------------------------------
module floppy_sector_image_access
  import fsia_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  // configuration
  input  logic                       cfg_write,
  input  logic [2:0]                 cfg_index,
  input  logic [13:0]                cfg_data,
  // input items
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 op,
  input  logic [7:0]                 track,
  input  logic [7:0]                 side,
  input  logic [7:0]                 sector,
  input  logic signed [14:0]         position,
  input  logic [7:0]                 byte_in,
  input  logic                       byte_ready,
  input  logic [IMAGE_ADDR_BITS-1:0] load_address,
  // result items
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [2:0]                 kind,
  output logic [7:0]                 value
);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_ADDR = 3'd2;
  localparam logic [2:0] S_RDAT = 3'd3;
  localparam logic [2:0] S_PUSH = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  // configuration registers
  geo_t        geo;
  logic [13:0] track_length;
  logic        write_protect;

  // latched item
  logic [1:0]                 op_q;
  logic [7:0]                 track_q;
  logic [7:0]                 side_q;
  logic [7:0]                 sector_q;
  logic [14:0]                position_q;
  logic [7:0]                 byte_in_q;
  logic                       byte_ready_q;
  logic [IMAGE_ADDR_BITS-1:0] load_address_q;

  // sector state
  logic [IMAGE_ADDR_BITS-1:0] sector_base;
  logic [IMAGE_ADDR_BITS-1:0] sector_base_next;
  logic [10:0]                byte_position;
  logic [10:0]                byte_position_next;
  logic                       sector_open;
  logic                       sector_open_next;

  // pending result
  logic [2:0] res_kind;
  logic [2:0] res_kind_next;
  logic [7:0] res_value;
  logic [7:0] res_value_next;

  // image memory port
  logic [7:0]                 image_store [IMAGE_DEPTH];
  logic                       mem_we;
  logic                       mem_re;
  logic [IMAGE_ADDR_BITS-1:0] mem_addr;
  logic [7:0]                 rd_data;

  // address unit
  logic      addr_start;
  addr_res_t addr_res;

  logic neg;
  logic in_sector;
  logic push;

  assign in_ready = (state == S_IDLE);
  assign push     = (state == S_PUSH) && (!out_valid || out_ready);
  assign neg      = position_q[14];
  assign in_sector = sector_open && (byte_position < sector_bytes(geo.size_code));

  fsia_sector_addr u_addr (
    .clk    (clk),
    .rst    (rst),
    .start  (addr_start),
    .track  (track_q),
    .side   (side_q),
    .sector (sector_q),
    .geo    (geo),
    .res    (addr_res)
  );

  // sequencer and access decode
  always_comb begin
    state_next         = state;
    res_kind_next      = res_kind;
    res_value_next     = res_value;
    sector_base_next   = sector_base;
    byte_position_next = byte_position;
    sector_open_next   = sector_open;
    mem_we             = 1'b0;
    mem_re             = 1'b0;
    mem_addr           = sector_base + IMAGE_ADDR_BITS'(byte_position);
    addr_start         = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next     = S_PUSH;
        res_value_next = 8'd0;
        case (op_q)
          OP_LOAD: begin
            mem_we         = 1'b1;
            mem_addr       = load_address_q;
            res_kind_next  = KIND_BYTE;
            res_value_next = byte_in_q;
          end
          OP_READ: begin
            if (neg) begin
              if (sector_q == SEC_ID) begin
                res_kind_next = KIND_ID;
              end else if (sector_q == SEC_INDEX) begin
                res_kind_next = KIND_INDEX;
              end else begin
                // open a data sector
                addr_start       = 1'b1;
                sector_open_next = 1'b0;
                state_next       = S_ADDR;
              end
            end else if (sector_q == SEC_ID) begin
              // id field: track, side, 1, size code, two crc bytes of zero
              res_kind_next = KIND_BYTE;
              case (position_q)
                15'd0:   res_value_next = track_q;
                15'd1:   res_value_next = side_q;
                15'd2:   res_value_next = 8'd1;
                15'd3:   res_value_next = {6'b0, geo.size_code};
                15'd4,
                15'd5:   res_value_next = 8'd0;
                default: res_kind_next  = KIND_CRC;
              endcase
            end else if (sector_q == SEC_INDEX) begin
              // index track reads zeros up to its length
              res_kind_next = (position_q >= {1'b0, track_length}) ? KIND_CRC : KIND_BYTE;
            end else if (in_sector) begin
              mem_re             = 1'b1;
              byte_position_next = byte_position + 11'd1;
              state_next         = S_RDAT;
            end else begin
              res_kind_next = KIND_CRC;
            end
          end
          OP_WRITE: begin
            if (write_protect) begin
              res_kind_next = KIND_REFUSED;
            end else if (neg) begin
              if (sector_q == SEC_INDEX || sector_q == SEC_RSVD) begin
                res_kind_next = KIND_ERROR;
              end else begin
                addr_start       = 1'b1;
                sector_open_next = 1'b0;
                state_next       = S_ADDR;
              end
            end else if (in_sector) begin
              if (!byte_ready_q) begin
                res_kind_next = KIND_NODATA;
              end else begin
                mem_we             = 1'b1;
                byte_position_next = byte_position + 11'd1;
                res_kind_next      = KIND_BYTE;
                res_value_next     = byte_in_q;
              end
            end else begin
              res_kind_next = KIND_CRC;
            end
          end
          default: res_kind_next = KIND_ERROR;
        endcase
      end
      S_ADDR: begin
        if (addr_res.done) begin
          state_next = S_PUSH;
          res_value_next = 8'd0;
          if (addr_res.ok) begin
            sector_base_next   = addr_res.base;
            byte_position_next = 11'd0;
            sector_open_next   = 1'b1;
            res_kind_next      = KIND_DATA;
          end else begin
            res_kind_next = KIND_NODATA;
          end
        end
      end
      S_RDAT: begin
        // registered memory data is valid now
        res_kind_next  = KIND_BYTE;
        res_value_next = rd_data;
        state_next     = S_PUSH;
      end
      S_PUSH: begin
        if (push) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // image memory, one access per cycle
  always_ff @(posedge clk) begin
    if (mem_we) image_store[mem_addr] <= byte_in_q;
    if (mem_re) rd_data <= image_store[mem_addr];
  end

  // control state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      sector_base       <= '0;
      byte_position     <= 11'd0;
      sector_open       <= 1'b0;
      out_valid         <= 1'b0;
      geo.side_count    <= 2'd1;
      geo.track_count   <= 8'd40;
      geo.sectors_per_track <= 8'd10;
      geo.size_code     <= 2'd1;
      geo.interlaced    <= 1'b0;
      geo.track_mapping <= 2'd0;
      track_length      <= 14'd3200;
      write_protect     <= 1'b1;
    end else begin
      state         <= state_next;
      sector_base   <= sector_base_next;
      byte_position <= byte_position_next;
      sector_open   <= sector_open_next;
      if (push) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_write) begin
        unique case (cfg_index)
          REG_SIDE_COUNT:   geo.side_count        <= cfg_data[1:0];
          REG_TRACK_COUNT:  geo.track_count       <= cfg_data[7:0];
          REG_SECTORS:      geo.sectors_per_track <= cfg_data[7:0];
          REG_SIZE_CODE:    geo.size_code         <= cfg_data[1:0];
          REG_INTERLACED:   geo.interlaced        <= cfg_data[0];
          REG_TRACK_MAP:    geo.track_mapping     <= cfg_data[1:0];
          REG_TRACK_LENGTH: track_length          <= cfg_data;
          REG_WRITE_PROT:   write_protect         <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_q           <= op;
      track_q        <= track;
      side_q         <= side;
      sector_q       <= sector;
      position_q     <= position;
      byte_in_q      <= byte_in;
      byte_ready_q   <= byte_ready;
      load_address_q <= load_address;
    end
    res_kind  <= res_kind_next;
    res_value <= res_value_next;
    if (push) begin
      kind  <= res_kind;
      value <= res_value;
    end
  end

  // checks
  a_addr_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    addr_res.done |-> state == S_ADDR)
    else $error("address unit answered outside its wait state");

  a_single_port: assert property (@(posedge clk) disable iff (rst)
    !(mem_we && mem_re))
    else $error("image memory read and written in one cycle");

  a_read_issued: assert property (@(posedge clk) disable iff (rst)
    state == S_RDAT |-> $past(mem_re))
    else $error("read data taken without a memory read");

  a_result_from_push: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_PUSH)
    else $error("output register loaded outside the push state");

  a_accept_to_exec: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == S_EXEC)
    else $error("accepted item not executed next cycle");

endmodule

/* verif/floppy_sector_image_access_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// floppy_sector_image_access_tb
// self-checking bench: a directed table of accesses, mostly with fixed expected
// answers, then random phases of sector opens, byte streams, id and index fields
// and noise under changing disk geometry, checked against a behavioral model
// ----------------------------------------------------------------------------
module floppy_sector_image_access_tb;
  import fsia_pkg::*;

  // op code outside the defined set, answered with an error
  localparam logic [1:0]  OP_BAD         = 2'd3;
  localparam int unsigned IMG_MASK       = IMAGE_DEPTH - 1;
  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          SETTLE_CYCLES  = 8;
  localparam int          RANDOM_ITEMS   = 1020;
  localparam int          SEQ_PER_PHASE  = 20;

  // one access item as driven on the input channel
  typedef struct packed {
    logic [1:0]                 op;
    logic [7:0]                 trk;
    logic [7:0]                 sd;
    logic [7:0]                 sec;
    logic signed [14:0]         pos;
    logic [7:0]                 data;
    logic                       rdy;
    logic [IMAGE_ADDR_BITS-1:0] laddr;
  } access_t;

  // one result item
  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] value;
  } answer_t;

  // directed table row: either a register write or an access item
  typedef struct {
    logic       is_cfg;
    logic [2:0] reg_idx;
    logic [13:0] reg_val;
    access_t    acc;
    logic       fixed;
    answer_t    ans;
  } dir_row_t;

  logic                       clk;
  logic                       rst;
  logic                       cfg_write;
  logic [2:0]                 cfg_index;
  logic [13:0]                cfg_data;
  logic                       in_valid;
  logic                       in_ready;
  logic [1:0]                 op;
  logic [7:0]                 track;
  logic [7:0]                 side;
  logic [7:0]                 sector;
  logic signed [14:0]         position;
  logic [7:0]                 byte_in;
  logic                       byte_ready;
  logic [IMAGE_ADDR_BITS-1:0] load_address;
  logic                       out_valid;
  logic                       out_ready;
  logic [2:0]                 kind;
  logic [7:0]                 value;

  floppy_sector_image_access u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .op           (op),
    .track        (track),
    .side         (side),
    .sector       (sector),
    .position     (position),
    .byte_in      (byte_in),
    .byte_ready   (byte_ready),
    .load_address (load_address),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .kind         (kind),
    .value        (value)
  );

  // 8 ns clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // ---------------------------------------------------------------------------
  // disk model state
  // ---------------------------------------------------------------------------
  // image bytes, only entries that were loaded or written exist
  logic [7:0]  img_mem [int unsigned];
  // geometry registers
  logic [1:0]  cfg_sides;
  logic [7:0]  cfg_tracks;
  logic [7:0]  cfg_spt;
  logic [1:0]  cfg_code;
  logic        cfg_lace;
  logic [1:0]  cfg_map;
  logic [13:0] cfg_tlen;
  logic        cfg_wp;
  // open sector
  int unsigned sec_base;
  logic [10:0] sec_pos;
  logic        sec_open;

  answer_t     answer_q[$];
  dir_row_t    dir_tab[$];
  int          errors;
  int          items_sent;
  int          idle_cycles;
  // when set, neither side inserts gaps
  bit          calm;

  function automatic int unsigned field_bytes();
    return 32'd128 << cfg_code;
  endfunction

  // locate a data sector in the image and open it; answers data mark or no data
  function automatic logic [2:0] open_field(input logic [7:0] trk, input logic [7:0] sd,
                                            input logic [7:0] sec);
    longint unsigned t, lsd, lsec, idx, base, nb;
    t    = trk;
    lsd  = sd;
    lsec = sec;
    nb   = field_bytes();
    sec_open = 1'b0;
    // track halving drops odd tracks, mapping three falls through as direct
    if (cfg_map == MAP_HALVE) begin
      if (t[0]) return KIND_NODATA;
      t = t >> 1;
    end else if (cfg_map == MAP_DOUBLE) begin
      t = t << 1;
    end
    if (lsec == 0) return KIND_NODATA;
    if (cfg_lace)
      idx = (t * cfg_sides + lsd) * cfg_spt + (lsec - 1);
    else
      idx = (lsd * cfg_tracks + t) * cfg_spt + (lsec - 1);
    base = idx * nb;
    // sector must lie wholly inside the image
    if (base + nb > IMAGE_DEPTH) return KIND_NODATA;
    sec_base = int'(base);
    sec_pos  = '0;
    sec_open = 1'b1;
    return KIND_DATA;
  endfunction

  // answer of the drive to one access, updating the model state
  function automatic answer_t predict_answer(input access_t a);
    answer_t     r;
    logic        neg;
    int unsigned addr;
    int unsigned nb;
    r.kind  = KIND_BYTE;
    r.value = 8'h00;
    neg     = a.pos[14];
    nb      = field_bytes();
    case (a.op)
      OP_LOAD: begin
        img_mem[a.laddr] = a.data;
        r.value = a.data;
      end
      OP_READ: begin
        if (neg) begin
          if (a.sec == SEC_ID)         r.kind = KIND_ID;
          else if (a.sec == SEC_INDEX) r.kind = KIND_INDEX;
          else                         r.kind = open_field(a.trk, a.sd, a.sec);
        end else if (a.sec == SEC_ID) begin
          // id field: track, side, one, size code, two crc zeros
          case (a.pos)
            0:       r.value = a.trk;
            1:       r.value = a.sd;
            2:       r.value = 8'h01;
            3:       r.value = {6'd0, cfg_code};
            4, 5:    r.value = 8'h00;
            default: r.kind  = KIND_CRC;
          endcase
        end else if (a.sec == SEC_INDEX) begin
          if ($unsigned(a.pos) >= cfg_tlen) r.kind = KIND_CRC;
        end else if (sec_open && sec_pos < nb) begin
          addr = (sec_base + sec_pos) & IMG_MASK;
          r.value = img_mem.exists(addr) ? img_mem[addr] : 8'h00;
          sec_pos = sec_pos + 11'd1;
        end else begin
          r.kind = KIND_CRC;
        end
      end
      OP_WRITE: begin
        if (cfg_wp) begin
          r.kind = KIND_REFUSED;
        end else if (neg) begin
          if (a.sec == SEC_INDEX || a.sec == SEC_RSVD) r.kind = KIND_ERROR;
          else r.kind = open_field(a.trk, a.sd, a.sec);
        end else if (sec_open && sec_pos < nb) begin
          if (!a.rdy) begin
            r.kind = KIND_NODATA;
          end else begin
            addr = (sec_base + sec_pos) & IMG_MASK;
            img_mem[addr] = a.data;
            sec_pos = sec_pos + 11'd1;
            r.value = a.data;
          end
        end else begin
          r.kind = KIND_CRC;
        end
      end
      default: r.kind = KIND_ERROR;
    endcase
    if (r.kind != KIND_BYTE) r.value = 8'h00;
    return r;
  endfunction

  function automatic void apply_reg(input logic [2:0] idx, input logic [13:0] val);
    case (idx)
      REG_SIDE_COUNT:   cfg_sides  = val[1:0];
      REG_TRACK_COUNT:  cfg_tracks = val[7:0];
      REG_SECTORS:      cfg_spt    = val[7:0];
      REG_SIZE_CODE:    cfg_code   = val[1:0];
      REG_INTERLACED:   cfg_lace   = val[0];
      REG_TRACK_MAP:    cfg_map    = val[1:0];
      REG_TRACK_LENGTH: cfg_tlen   = val;
      REG_WRITE_PROT:   cfg_wp     = val[0];
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic access_t mk_access(input logic [1:0] o, input logic [7:0] t,
                                        input logic [7:0] s, input logic [7:0] c,
                                        input logic signed [14:0] p, input logic [7:0] d,
                                        input logic rd, input logic [IMAGE_ADDR_BITS-1:0] la);
    access_t a;
    a.op = o; a.trk = t; a.sd = s; a.sec = c;
    a.pos = p; a.data = d; a.rdy = rd; a.laddr = la;
    return a;
  endfunction

  function automatic logic [7:0] rnd8();
    return 8'($urandom);
  endfunction

  function automatic logic rnd1();
    return 1'($urandom);
  endfunction

  function automatic logic [IMAGE_ADDR_BITS-1:0] rnd_addr();
    return IMAGE_ADDR_BITS'($urandom);
  endfunction

  // negative position with random low bits opens a field
  function automatic logic signed [14:0] open_pos();
    return {1'b1, 14'($urandom)};
  endfunction

  function automatic logic signed [14:0] data_pos();
    return {1'b0, 14'($urandom)};
  endfunction

  // gap length: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void add_acc(input access_t a, input logic fixed, input logic [2:0] k,
                                  input logic [7:0] v);
    dir_row_t row;
    row.is_cfg  = 1'b0;
    row.reg_idx = REG_SIDE_COUNT;
    row.reg_val = '0;
    row.acc     = a;
    row.fixed   = fixed;
    row.ans     = answer_t'{k, v};
    dir_tab.push_back(row);
  endfunction

  function automatic void add_cfg(input logic [2:0] idx, input logic [13:0] val);
    dir_row_t row;
    row.is_cfg  = 1'b1;
    row.reg_idx = idx;
    row.reg_val = val;
    row.acc     = '0;
    row.fixed   = 1'b0;
    row.ans     = '0;
    dir_tab.push_back(row);
  endfunction

  // one register write, only while the block is idle
  task automatic write_reg(input logic [2:0] idx, input logic [13:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    apply_reg(idx, val);
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // drop valid, wait until every result is back, then let the block settle
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (answer_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // drive one item, wait for its handshake, then record its answer
  task automatic send_one(input access_t a, input logic fixed, input answer_t ans);
    int      gap;
    answer_t pred;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid     <= 1'b1;
    op           <= a.op;
    track        <= a.trk;
    side         <= a.sd;
    sector       <= a.sec;
    position     <= a.pos;
    byte_in      <= a.data;
    byte_ready   <= a.rdy;
    load_address <= a.laddr;
    do @(posedge clk); while (!in_ready);
    pred = predict_answer(a);
    answer_q.push_back(fixed ? ans : pred);
    items_sent++;
  endtask

  // a data byte read of a never written image entry is preceded by a load of it
  task automatic send_checked(input access_t a, input logic fixed, input answer_t ans);
    int unsigned addr;
    if (a.op == OP_READ && !a.pos[14] && a.sec != SEC_ID && a.sec != SEC_INDEX &&
        sec_open && sec_pos < field_bytes()) begin
      addr = (sec_base + sec_pos) & IMG_MASK;
      if (!img_mem.exists(addr))
        send_one(mk_access(OP_LOAD, rnd8(), rnd8(), rnd8(), data_pos(), rnd8(), rnd1(),
                           IMAGE_ADDR_BITS'(addr)), 1'b0, '0);
    end
    send_one(a, fixed, ans);
  endtask

  task automatic send(input access_t a);
    send_checked(a, 1'b0, '0);
  endtask

  // small geometry so most opens land inside the image
  task automatic pick_geo(output logic [7:0] t, output logic [7:0] s, output logic [7:0] c);
    int hi;
    hi = (cfg_spt < 4) ? int'(cfg_spt) : 4;
    t = ($urandom_range(0, 9) == 0) ? rnd8() : 8'($urandom_range(0, 3));
    s = ($urandom_range(0, 9) == 0) ? rnd8() : 8'($urandom_range(0, 1));
    c = ($urandom_range(0, 9) == 0) ? rnd8() : 8'($urandom_range(1, hi));
  endtask

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3 && field_bytes() <= 256) return field_bytes() + 1;
    if (r < 70) return $urandom_range(1, 6);
    return $urandom_range(7, 20);
  endfunction

  task automatic seq_read(input logic [7:0] t, input logic [7:0] s, input logic [7:0] c,
                          input int n);
    int cnt;
    cnt = n;
    send(mk_access(OP_READ, t, s, c, open_pos(), rnd8(), rnd1(), rnd_addr()));
    // a failed open only gives crc, keep that short
    if (!sec_open && cnt > 2) cnt = 2;
    repeat (cnt) send(mk_access(OP_READ, t, s, c, data_pos(), rnd8(), rnd1(), rnd_addr()));
  endtask

  task automatic seq_write(input logic [7:0] t, input logic [7:0] s, input logic [7:0] c,
                           input int n);
    int cnt;
    cnt = n;
    send(mk_access(OP_WRITE, t, s, c, open_pos(), rnd8(), rnd1(), rnd_addr()));
    if ((cfg_wp || !sec_open) && cnt > 2) cnt = 2;
    repeat (cnt)
      send(mk_access(OP_WRITE, t, s, c, data_pos(), rnd8(), ($urandom_range(0, 9) != 0),
                     rnd_addr()));
    // now and then read back what was just written
    if (rnd1()) seq_read(t, s, c, cnt);
  endtask

  task automatic seq_id(input logic [7:0] t, input logic [7:0] s);
    send(mk_access(OP_READ, t, s, SEC_ID, open_pos(), rnd8(), rnd1(), rnd_addr()));
    repeat (6)
      send(mk_access(OP_READ, t, s, SEC_ID, 15'($urandom_range(0, 7)), rnd8(), rnd1(),
                     rnd_addr()));
  endtask

  task automatic seq_index();
    send(mk_access(OP_READ, rnd8(), rnd8(), SEC_INDEX, open_pos(), rnd8(), rnd1(),
                   rnd_addr()));
    // both sides of the index track end, then anywhere
    send(mk_access(OP_READ, rnd8(), rnd8(), SEC_INDEX, 15'(cfg_tlen - 14'd1), rnd8(), rnd1(),
                   rnd_addr()));
    send(mk_access(OP_READ, rnd8(), rnd8(), SEC_INDEX, 15'(cfg_tlen), rnd8(), rnd1(),
                   rnd_addr()));
    send(mk_access(OP_READ, rnd8(), rnd8(), SEC_INDEX, data_pos(), rnd8(), rnd1(),
                   rnd_addr()));
  endtask

  // fully random item, sector biased toward the special numbers
  task automatic seq_noise();
    logic [7:0] c;
    case ($urandom_range(0, 5))
      0:       c = SEC_ID;
      1:       c = SEC_RSVD;
      2:       c = SEC_INDEX;
      3:       c = 8'h00;
      default: c = rnd8();
    endcase
    send(mk_access(2'($urandom), rnd8(), rnd8(), c, 15'($urandom), rnd8(), rnd1(),
                   rnd_addr()));
  endtask

  // write a whole sector past its end, then read it all back past its end
  task automatic seq_full_sector();
    int nb;
    nb = field_bytes();
    send(mk_access(OP_WRITE, 8'd0, 8'd0, 8'd1, open_pos(), rnd8(), rnd1(), rnd_addr()));
    repeat (nb + 1)
      send(mk_access(OP_WRITE, 8'd0, 8'd0, 8'd1, data_pos(), rnd8(), 1'b1, rnd_addr()));
    seq_read(8'd0, 8'd0, 8'd1, nb + 1);
  endtask

  // geometry of one random phase: the two extremes first, then mixed settings
  task automatic set_phase_config(input int ph);
    logic [13:0] v [8];
    if (ph == 0) begin
      v = '{14'd1, 14'd1, 14'd1, 14'd0, 14'd0, 14'd0, 14'd3200, 14'd0};
    end else if (ph == 1) begin
      v = '{14'd2, 14'd255, 14'd255, 14'd3, 14'd1, 14'd2, 14'd12800, 14'd1};
    end else begin
      v[REG_SIDE_COUNT]   = 14'($urandom_range(1, 2));
      v[REG_TRACK_COUNT]  = rnd1() ? 14'($urandom_range(1, 40)) : 14'($urandom_range(1, 255));
      v[REG_SECTORS]      = rnd1() ? 14'($urandom_range(1, 16)) : 14'($urandom_range(1, 255));
      v[REG_SIZE_CODE]    = rnd1() ? 14'd0 : 14'($urandom_range(0, 3));
      v[REG_INTERLACED]   = 14'(rnd1());
      // mapping three now and then, it behaves as direct
      v[REG_TRACK_MAP]    = ($urandom_range(0, 9) == 0) ? 14'd3 : 14'($urandom_range(0, 2));
      v[REG_TRACK_LENGTH] = 14'($urandom_range(3200, 12800));
      v[REG_WRITE_PROT]   = ($urandom_range(0, 3) == 0) ? 14'd1 : 14'd0;
      // the full sector pass wants small writable sectors
      if (ph == 2) begin
        v[REG_SIZE_CODE]  = 14'd0;
        v[REG_WRITE_PROT] = 14'd0;
      end
    end
    for (int i = 0; i < 8; i++) write_reg(3'(i), v[i]);
  endtask

  // ---------------------------------------------------------------------------
  // result receiver with random stalls
  // ---------------------------------------------------------------------------
  initial begin
    int hold;
    hold = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        out_ready <= 1'b0;
        hold--;
      end else begin
        out_ready <= 1'b1;
        hold = pick_gap();
      end
    end
  end

  // every accepted result against the oldest outstanding answer
  always @(posedge clk) begin
    answer_t want;
    if (!rst && out_valid && out_ready) begin
      if (answer_q.size() == 0) begin
        $error("result item with nothing outstanding: kind %0d value 0x%02h", kind, value);
        errors++;
      end else begin
        want = answer_q.pop_front();
        if (kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, kind);
          errors++;
        end
        if (value !== want.value) begin
          $error("value: expected 0x%02h, got 0x%02h", want.value, value);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int         ph;
    int         r;
    int         start_items;
    logic [7:0] t, s, c;
    dir_row_t   row;

    // every input known from time zero
    rst          = 1'b1;
    cfg_write    = 1'b0;
    cfg_index    = REG_SIDE_COUNT;
    cfg_data     = '0;
    in_valid     = 1'b0;
    op           = OP_READ;
    track        = '0;
    side         = '0;
    sector       = '0;
    position     = '0;
    byte_in      = '0;
    byte_ready   = 1'b0;
    load_address = '0;
    errors       = 0;
    items_sent   = 0;
    calm         = 1'b0;

    // reset values of the geometry and the sector
    cfg_sides  = 2'd1;
    cfg_tracks = 8'd40;
    cfg_spt    = 8'd10;
    cfg_code   = 2'd1;
    cfg_lace   = 1'b0;
    cfg_map    = 2'd0;
    cfg_tlen   = 14'd3200;
    cfg_wp     = 1'b1;
    sec_base   = 0;
    sec_pos    = '0;
    sec_open   = 1'b0;

    // directed table, starting from the reset geometry
    // id field of track ab side 5a, then past its end
    add_acc(mk_access(OP_READ, 8'hab, 8'h5a, SEC_ID, -15'sd1, 8'h00, 1'b0, '0),
            1'b1, KIND_ID, 8'h00);
    add_acc(mk_access(OP_READ, 8'hab, 8'h5a, SEC_ID, 15'sd0, 8'h00, 1'b0, '0),
            1'b1, KIND_BYTE, 8'hab);
    add_acc(mk_access(OP_READ, 8'hab, 8'h5a, SEC_ID, 15'sd1, 8'h00, 1'b0, '0),
            1'b1, KIND_BYTE, 8'h5a);
    add_acc(mk_access(OP_READ, 8'hab, 8'h5a, SEC_ID, 15'sd2, 8'h00, 1'b0, '0),
            1'b1, KIND_BYTE, 8'h01);
    add_acc(mk_access(OP_READ, 8'hab, 8'h5a, SEC_ID, 15'sd3, 8'h00, 1'b0, '0),
            1'b1, KIND_BYTE, 8'h01);
    add_acc(mk_access(OP_READ, 8'hab, 8'h5a, SEC_ID, 15'sd5, 8'h00, 1'b0, '0),
            1'b1, KIND_BYTE, 8'h00);
    add_acc(mk_access(OP_READ, 8'hab, 8'h5a, SEC_ID, 15'sd6, 8'h00, 1'b0, '0),
            1'b1, KIND_CRC, 8'h00);
    // index track: mark, last byte, first crc position
    add_acc(mk_access(OP_READ, 8'h00, 8'h00, SEC_INDEX, -15'sd16384, 8'h00, 1'b0, '0),
            1'b1, KIND_INDEX, 8'h00);
    add_acc(mk_access(OP_READ, 8'h00, 8'h00, SEC_INDEX, 15'sd3199, 8'h00, 1'b0, '0),
            1'b1, KIND_BYTE, 8'h00);
    add_acc(mk_access(OP_READ, 8'h00, 8'h00, SEC_INDEX, 15'sd3200, 8'h00, 1'b0, '0),
            1'b1, KIND_CRC, 8'h00);
    // data read with nothing opened since reset
    add_acc(mk_access(OP_READ, 8'h00, 8'h00, 8'h01, 15'sd0, 8'h00, 1'b0, '0),
            1'b1, KIND_CRC, 8'h00);
    // write protected after reset
    add_acc(mk_access(OP_WRITE, 8'h00, 8'h00, 8'h01, -15'sd1, 8'h00, 1'b1, '0),
            1'b1, KIND_REFUSED, 8'h00);
    add_acc(mk_access(OP_BAD, 8'hff, 8'hff, 8'hff, 15'sd16383, 8'hff, 1'b1, '1),
            1'b1, KIND_ERROR, 8'h00);
    // loads at both ends of the image
    add_acc(mk_access(OP_LOAD, 8'h00, 8'h00, 8'h00, 15'sd0, 8'hff, 1'b0, '0),
            1'b1, KIND_BYTE, 8'hff);
    add_acc(mk_access(OP_LOAD, 8'hff, 8'hff, 8'hff, -15'sd1, 8'h00, 1'b1, '1),
            1'b1, KIND_BYTE, 8'h00);
    // sector zero fails and leaves the sector closed
    add_acc(mk_access(OP_READ, 8'h00, 8'h00, 8'h00, -15'sd1, 8'h00, 1'b0, '0),
            1'b1, KIND_NODATA, 8'h00);
    add_acc(mk_access(OP_READ, 8'h00, 8'h00, 8'h00, 15'sd0, 8'h00, 1'b0, '0),
            1'b1, KIND_CRC, 8'h00);
    // sector far past the image end
    add_acc(mk_access(OP_READ, 8'hff, 8'hff, 8'hfc, -15'sd1, 8'h00, 1'b0, '0),
            1'b1, KIND_NODATA, 8'h00);
    // first sector sits at image address zero
    add_acc(mk_access(OP_READ, 8'h00, 8'h00, 8'h01, -15'sd1, 8'h00, 1'b0, '0),
            1'b1, KIND_DATA, 8'h00);
    add_acc(mk_access(OP_READ, 8'h00, 8'h00, 8'h01, 15'sd0, 8'h00, 1'b0, '0),
            1'b1, KIND_BYTE, 8'hff);
    // writes enabled: index and reserved opens are errors
    add_cfg(REG_WRITE_PROT, 14'd0);
    add_acc(mk_access(OP_WRITE, 8'h00, 8'h00, SEC_INDEX, -15'sd1, 8'h00, 1'b1, '0),
            1'b1, KIND_ERROR, 8'h00);
    add_acc(mk_access(OP_WRITE, 8'h00, 8'h00, SEC_RSVD, -15'sd1, 8'h00, 1'b1, '0),
            1'b1, KIND_ERROR, 8'h00);
    // byte not ready, then a real write into the still open sector
    add_acc(mk_access(OP_WRITE, 8'h00, 8'h00, 8'h01, 15'sd0, 8'h55, 1'b0, '0),
            1'b1, KIND_NODATA, 8'h00);
    add_acc(mk_access(OP_WRITE, 8'h00, 8'h00, 8'h01, 15'sd16383, 8'h3c, 1'b1, '0),
            1'b1, KIND_BYTE, 8'h3c);
    // id sector number at a data position is an ordinary data write
    add_acc(mk_access(OP_WRITE, 8'h00, 8'h00, SEC_ID, 15'sd1, 8'hc3, 1'b1, '0),
            1'b0, KIND_BYTE, 8'h00);
    // halving rejects an odd track and closes the sector
    add_cfg(REG_TRACK_MAP, 14'(MAP_HALVE));
    add_acc(mk_access(OP_READ, 8'h03, 8'h00, 8'h01, -15'sd1, 8'h00, 1'b0, '0),
            1'b1, KIND_NODATA, 8'h00);
    add_acc(mk_access(OP_READ, 8'h03, 8'h00, 8'h01, 15'sd0, 8'h00, 1'b0, '0),
            1'b1, KIND_CRC, 8'h00);

    // reset held at the start, released once
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i]) begin
      row = dir_tab[i];
      if (row.is_cfg) begin
        wait_idle();
        write_reg(row.reg_idx, row.reg_val);
      end else begin
        send_checked(row.acc, row.fixed, row.ans);
      end
    end

    // random phases, each under a fresh geometry
    start_items = items_sent;
    ph = 0;
    while (items_sent - start_items < RANDOM_ITEMS) begin
      wait_idle();
      set_phase_config(ph);
      calm = ($urandom_range(0, 3) == 0);
      if (ph == 2) seq_full_sector();
      for (int k = 0; k < SEQ_PER_PHASE && items_sent - start_items < RANDOM_ITEMS; k++) begin
        // sender holds off until the block has drained
        if (k == SEQ_PER_PHASE / 2) wait_idle();
        pick_geo(t, s, c);
        r = $urandom_range(0, 99);
        if (r < 40)      seq_read(t, s, c, pick_len());
        else if (r < 65) seq_write(t, s, c, pick_len());
        else if (r < 73) seq_id(t, s);
        else if (r < 80) seq_index();
        else             seq_noise();
      end
      ph++;
    end

    // drain and let any stray result show up
    wait_idle();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* floppy_sector_image_access.f */
hdl/fsia_pkg.sv
hdl/fsia_sector_addr.sv
hdl/floppy_sector_image_access.sv
verif/floppy_sector_image_access_tb.sv
